FILE: sv/isq_pkg.sv
// Shared types, codes and constants for the indexed sequence store.
package isq_pkg;

   // Default number of entries in the store
   localparam int CAPACITY_DEF = 256;

   // Fixed field widths
   localparam int VALUE_W = 32;
   localparam int POS_W   = 16;
   localparam int COUNT_W = 16;
   localparam int OCC_W   = 9;
   localparam int CODE_W  = 3;
   localparam int STAT_W  = 2;

   // Request codes
   localparam logic [CODE_W-1:0] REQ_INSERT = 3'd0;
   localparam logic [CODE_W-1:0] REQ_ERASE  = 3'd1;
   localparam logic [CODE_W-1:0] REQ_GET    = 3'd2;
   localparam logic [CODE_W-1:0] REQ_SET    = 3'd3;
   localparam logic [CODE_W-1:0] REQ_SIZE   = 3'd4;

   // Status codes
   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Request word
   typedef struct packed {
      logic [CODE_W-1:0]  req_type;
      logic [POS_W-1:0]   position;
      value_type          item_value;
      logic [COUNT_W-1:0] erase_count;
      logic               run_continue;
   } req_word_type;

   // Response word
   typedef struct packed {
      value_type         read_value;
      logic [OCC_W-1:0]  occupancy;
      logic [STAT_W-1:0] status;
   } rsp_word_type;

   // Operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT_DOWN,
      CELL_WRITE,
      CELL_LOAD_READ,
      CELL_SHIFT_READ
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [POS_W-1:0] pos;
      value_type        value;
   } cell_ctrl_type;

endpackage

FILE: sv/indexed_sequence_store.sv
// Indexed sequence store top level: request sequencer and chain of storage cells.
//
// Usage: present a request word on req_word and raise start; the word is
// taken at a rising edge where start is high and busy is low. Every request
// gives exactly one response word on rsp_word, marked by rsp_strobe for one
// cycle; the receiver must take it then, it cannot hold it off.
// Behaviour per request kind:
//   insert, set, size, and any request rejected for range or full:
//     the response word is registered, busy stays low, one request per cycle.
//   erase of n entries (n > 0): the cell chain moves the tail down one place
//     per cycle, so busy is high until n places are shifted, then the response is given.
//   get at position p: every cell copies its entry into a read-out stage and
//     the chain walks it down to cell zero one place per cycle; the response
//     carries the value once it reaches cell zero.
// A new request is taken in the cycle that carries the previous response.
// Reset empties the store (fill level and insert cursor to zero); entries are
// not cleared and are never read before they are written.
module indexed_sequence_store #(
   parameter int CAPACITY = isq_pkg::CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  isq_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output isq_pkg::rsp_word_type rsp_word
);

   isq_pkg::cell_ctrl_type cell_ctrl;
   isq_pkg::value_type     entry_q [CAPACITY];
   isq_pkg::value_type     rd_q    [CAPACITY];

   // Sequencer
   isq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .head_rd    (rd_q[0]),
      .cell_ctrl  (cell_ctrl)
   );

   // Chain of cells, each linked to its neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      isq_pkg::value_type left_v, right_v, right_r;

      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_left
         assign left_v = entry_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
         assign right_r = '0;
      end else begin : g_right
         assign right_v = entry_q[i+1];
         assign right_r = rd_q[i+1];
      end

      isq_cell #(
         .IDX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .left_value  (left_v),
         .right_value (right_v),
         .right_rd    (right_r),
         .entry_value (entry_q[i]),
         .rd_value    (rd_q[i])
      );
   end

endmodule

FILE: sv/isq_cell.sv
// One storage cell of the chain: holds one entry and one read-out stage.
module isq_cell #(
   parameter int IDX = 0
) (
   input  logic                   clock,
   input  isq_pkg::cell_ctrl_type ctrl,
   input  isq_pkg::value_type     left_value,
   input  isq_pkg::value_type     right_value,
   input  isq_pkg::value_type     right_rd,
   output isq_pkg::value_type     entry_value,
   output isq_pkg::value_type     rd_value
);

   localparam int PW = isq_pkg::POS_W;
   localparam logic [PW-1:0] MY_POS = PW'(IDX);

   isq_pkg::value_type entry_ff, entry_in;
   isq_pkg::value_type rd_ff, rd_in;

   // Local decode of the broadcast operation
   always_comb begin
      entry_in = entry_ff;
      rd_in    = rd_ff;
      unique case (ctrl.op)
         isq_pkg::CELL_HOLD: begin
         end
         isq_pkg::CELL_INSERT: begin
            if (MY_POS > ctrl.pos) begin
               entry_in = left_value;
            end else if (MY_POS == ctrl.pos) begin
               entry_in = ctrl.value;
            end
         end
         isq_pkg::CELL_SHIFT_DOWN: begin
            if (MY_POS >= ctrl.pos) begin
               entry_in = right_value;
            end
         end
         isq_pkg::CELL_WRITE: begin
            if (MY_POS == ctrl.pos) begin
               entry_in = ctrl.value;
            end
         end
         isq_pkg::CELL_LOAD_READ: begin
            rd_in = entry_ff;
         end
         isq_pkg::CELL_SHIFT_READ: begin
            rd_in = right_rd;
         end
         default: begin
         end
      endcase
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      rd_ff    <= rd_in;
   end

   assign entry_value = entry_ff;
   assign rd_value    = rd_ff;

endmodule

FILE: sv/isq_ctrl.sv
// Request sequencer: decodes words, tracks fill level and cursor, drives the cell chain.
module isq_ctrl #(
   parameter int CAPACITY = isq_pkg::CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  isq_pkg::req_word_type  req_word,
   output logic                   rsp_strobe,
   output isq_pkg::rsp_word_type  rsp_word,
   input  isq_pkg::value_type     head_rd,
   output isq_pkg::cell_ctrl_type cell_ctrl
);

   localparam int FW = $clog2(CAPACITY + 1);
   localparam int PW = isq_pkg::POS_W;
   localparam int CW = (FW > PW) ? FW : PW;
   localparam int OW = isq_pkg::OCC_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ERASE,
      ST_GET
   } state_type;

   state_type                   state_ff, state_in;
   logic [FW-1:0]               fill_ff, fill_in;
   logic [FW-1:0]               cursor_ff, cursor_in;
   logic [FW-1:0]               left_ff, left_in;
   isq_pkg::cell_ctrl_type      cell_ff, cell_in;
   logic                        strobe_ff, strobe_in;
   logic [isq_pkg::STAT_W-1:0]  status_ff, status_in;
   logic                        rd_sel_ff, rd_sel_in;

   logic [CW-1:0] pos_ext, fill_ext, cursor_ext, cnt_ext;
   logic [CW-1:0] base, at, avail, n_del;
   logic          pos_in_range;

   // Shared arithmetic on the incoming word
   always_comb begin
      pos_ext      = CW'(req_word.position);
      fill_ext     = CW'(fill_ff);
      cursor_ext   = CW'(cursor_ff);
      cnt_ext      = CW'(req_word.erase_count);
      base         = req_word.run_continue ? cursor_ext : pos_ext;
      at           = (base > fill_ext) ? fill_ext : base;
      pos_in_range = pos_ext < fill_ext;
      avail        = fill_ext - pos_ext;
      n_del        = (cnt_ext < avail) ? cnt_ext : avail;
   end

   // Next state
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      cursor_in = cursor_ff;
      left_in   = left_ff;
      cell_in   = '{op: isq_pkg::CELL_HOLD, pos: '0, value: '0};
      strobe_in = 1'b0;
      status_in = status_ff;
      rd_sel_in = rd_sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               strobe_in = 1'b1;
               status_in = isq_pkg::STATUS_OK;
               rd_sel_in = 1'b0;
               unique case (req_word.req_type)
                  isq_pkg::REQ_INSERT: begin
                     if (fill_ff >= FW'(CAPACITY)) begin
                        status_in = isq_pkg::STATUS_FULL;
                     end else begin
                        cell_in   = '{op: isq_pkg::CELL_INSERT, pos: PW'(at),
                                      value: req_word.item_value};
                        fill_in   = fill_ff + FW'(1);
                        cursor_in = FW'(at + CW'(1));
                     end
                  end
                  isq_pkg::REQ_ERASE: begin
                     if (!pos_in_range) begin
                        status_in = isq_pkg::STATUS_RANGE;
                     end else if (n_del != '0) begin
                        // shift the tail down one place per cycle
                        strobe_in = 1'b0;
                        state_in  = ST_ERASE;
                        left_in   = FW'(n_del);
                        fill_in   = fill_ff - FW'(n_del);
                        cell_in   = '{op: isq_pkg::CELL_SHIFT_DOWN,
                                      pos: req_word.position, value: '0};
                     end
                  end
                  isq_pkg::REQ_GET: begin
                     if (!pos_in_range) begin
                        status_in = isq_pkg::STATUS_RANGE;
                     end else begin
                        // snapshot, then walk the word down to cell zero
                        strobe_in = 1'b0;
                        state_in  = ST_GET;
                        left_in   = FW'(pos_ext);
                        cell_in   = '{op: isq_pkg::CELL_LOAD_READ, pos: '0, value: '0};
                     end
                  end
                  isq_pkg::REQ_SET: begin
                     if (!pos_in_range) begin
                        status_in = isq_pkg::STATUS_RANGE;
                     end else begin
                        cell_in = '{op: isq_pkg::CELL_WRITE, pos: req_word.position,
                                    value: req_word.item_value};
                     end
                  end
                  default: begin
                     // size and unused codes report occupancy only
                  end
               endcase
            end
         end
         ST_ERASE: begin
            left_in = left_ff - FW'(1);
            if (left_ff == FW'(1)) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
            end else begin
               cell_in = cell_ff;
            end
         end
         ST_GET: begin
            if (left_ff == '0) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               rd_sel_in = 1'b1;
            end else begin
               left_in = left_ff - FW'(1);
               cell_in = '{op: isq_pkg::CELL_SHIFT_READ, pos: '0, value: '0};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         cursor_ff <= '0;
         left_ff   <= '0;
         cell_ff   <= '{op: isq_pkg::CELL_HOLD, pos: '0, value: '0};
         strobe_ff <= 1'b0;
         status_ff <= isq_pkg::STATUS_OK;
         rd_sel_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         cursor_ff <= cursor_in;
         left_ff   <= left_in;
         cell_ff   <= cell_in;
         strobe_ff <= strobe_in;
         status_ff <= status_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_word.read_value = rd_sel_ff ? head_rd : '0;
   assign rsp_word.occupancy  = OW'(fill_ff);
   assign rsp_word.status     = status_ff;
   assign cell_ctrl           = cell_ff;

   // Checks
   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !strobe_ff)
      else $error("response word while a request is still running");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(CAPACITY))
      else $error("fill level beyond capacity");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= FW'(CAPACITY))
      else $error("insert cursor beyond capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && status_ff == isq_pkg::STATUS_FULL) |-> (fill_ff == FW'(CAPACITY)))
      else $error("full status reported while store has room");

   a_erase_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ERASE) |-> (left_ff != '0 && cell_ff.op == isq_pkg::CELL_SHIFT_DOWN))
      else $error("erase running without shift count");

endmodule

FILE: bench/indexed_sequence_store_tb.sv
// Self-checking testbench for the indexed sequence store: directed and random request words.
module indexed_sequence_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH    = isq_pkg::CAPACITY_DEF;
   localparam int RANDOM_ITEMS   = 1750;
   localparam int QUIET_TAIL     = 250;
   // the limit must outlast a full-depth get or erase, during which no word is accepted
   localparam int WATCHDOG_LIMIT = 8 * STORE_DEPTH;
   localparam int DRAIN_CYCLES   = STORE_DEPTH + 40;
   localparam int PRINT_LIMIT    = 40;

   // request codes the block treats like a size request
   localparam logic [isq_pkg::CODE_W-1:0] REQ_SPARE_LO = 3'd5;
   localparam logic [isq_pkg::CODE_W-1:0] REQ_SPARE_HI = 3'd7;

   typedef enum {MODE_GROW, MODE_FILL, MODE_SHRINK, MODE_MIX} mix_mode_type;

   // Shadow store: predicts each response word and checks the ones that arrive
   class sequence_scoreboard;
      isq_pkg::value_type    stored [STORE_DEPTH];
      int                    depth;
      int                    cursor;
      isq_pkg::rsp_word_type awaited [$];
      int                    mismatches;
      int                    checked;
      int                    full_rejects;
      int                    range_rejects;
      int                    peak_depth;
      int                    op_seen [isq_pkg::REQ_SIZE + 1];

      function new();
         depth         = 0;
         cursor        = 0;
         mismatches    = 0;
         checked       = 0;
         full_rejects  = 0;
         range_rejects = 0;
         peak_depth    = 0;
         foreach (op_seen[i]) op_seen[i] = 0;
      endfunction

      // Apply an accepted request word and queue the response it must give
      function void note_request(isq_pkg::req_word_type w);
         isq_pkg::rsp_word_type want;
         int                    at;
         int                    span;
         int                    pos;
         pos  = w.position;
         want = '0;
         want.status = isq_pkg::STATUS_OK;
         case (w.req_type)
            isq_pkg::REQ_INSERT: begin
               if (depth >= STORE_DEPTH) begin
                  want.status = isq_pkg::STATUS_FULL;
               end else begin
                  at = w.run_continue ? cursor : pos;
                  // cursor or position past the end appends
                  if (at > depth) at = depth;
                  for (int i = depth; i > at; i--) stored[i] = stored[i - 1];
                  stored[at] = w.item_value;
                  depth++;
                  cursor = at + 1;
               end
            end
            isq_pkg::REQ_ERASE: begin
               if (pos >= depth) begin
                  want.status = isq_pkg::STATUS_RANGE;
               end else begin
                  // only entries that exist are removed; cursor is left alone
                  span = w.erase_count;
                  if (span > depth - pos) span = depth - pos;
                  for (int i = pos; i + span < depth; i++) stored[i] = stored[i + span];
                  depth -= span;
               end
            end
            isq_pkg::REQ_GET: begin
               if (pos < depth) want.read_value = stored[pos];
               else want.status = isq_pkg::STATUS_RANGE;
            end
            isq_pkg::REQ_SET: begin
               if (pos < depth) stored[pos] = w.item_value;
               else want.status = isq_pkg::STATUS_RANGE;
            end
            default: ;
         endcase
         want.occupancy = isq_pkg::OCC_W'(depth);
         if (want.status == isq_pkg::STATUS_FULL) full_rejects++;
         if (want.status == isq_pkg::STATUS_RANGE) range_rejects++;
         if (depth > peak_depth) peak_depth = depth;
         op_seen[(w.req_type > isq_pkg::REQ_SIZE) ? isq_pkg::REQ_SIZE : w.req_type]++;
         awaited.push_back(want);
      endfunction

      task report_mismatch(string what, logic [isq_pkg::VALUE_W-1:0] got_v,
                           logic [isq_pkg::VALUE_W-1:0] want_v);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("mismatch at %0t: %s: got %h, expected %h", $time, what, got_v, want_v);
      endtask

      // Compare a response word field by field with the oldest prediction
      task check_response(isq_pkg::rsp_word_type got);
         isq_pkg::rsp_word_type want;
         checked++;
         if (awaited.size() == 0) begin
            report_mismatch("response word with none awaited",
                            isq_pkg::VALUE_W'(got.occupancy), '0);
         end else begin
            want = awaited.pop_front();
            if (got.read_value !== want.read_value)
               report_mismatch("read_value", got.read_value, want.read_value);
            if (got.occupancy !== want.occupancy)
               report_mismatch("occupancy", isq_pkg::VALUE_W'(got.occupancy),
                               isq_pkg::VALUE_W'(want.occupancy));
            if (got.status !== want.status)
               report_mismatch("status", isq_pkg::VALUE_W'(got.status),
                               isq_pkg::VALUE_W'(want.status));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   isq_pkg::req_word_type req_word;
   logic                  rsp_strobe;
   isq_pkg::rsp_word_type rsp_word;

   sequence_scoreboard sb;
   int quiet_cycles;
   int planned_depth;

   indexed_sequence_store u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // 2 ns clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Monitor: take accepted words on both sides, and stop a hung run
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (start && !busy) sb.note_request(req_word);
         if (rsp_strobe) sb.check_response(rsp_word);
         if ((start && !busy) || rsp_strobe) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   function automatic isq_pkg::req_word_type make_word(logic [isq_pkg::CODE_W-1:0] code,
                                                       int pos, isq_pkg::value_type value,
                                                       int count, bit run);
      isq_pkg::req_word_type w;
      w.req_type     = code;
      w.position     = isq_pkg::POS_W'(pos);
      w.item_value   = value;
      w.erase_count  = isq_pkg::COUNT_W'(count);
      w.run_continue = run;
      return w;
   endfunction

   // Stimulus-side estimate of the fill level, used only to aim positions
   function automatic void track_depth(isq_pkg::req_word_type w);
      int span;
      if (w.req_type == isq_pkg::REQ_INSERT && planned_depth < STORE_DEPTH) begin
         planned_depth++;
      end else if (w.req_type == isq_pkg::REQ_ERASE && w.position < planned_depth) begin
         span = w.erase_count;
         if (span > planned_depth - w.position) span = planned_depth - w.position;
         planned_depth -= span;
      end
   endfunction

   // Mostly inside the sequence, some just past the end, some anywhere
   function automatic logic [isq_pkg::POS_W-1:0] pick_position();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return (planned_depth == 0) ? '0 :
                isq_pkg::POS_W'($urandom_range(0, planned_depth - 1));
      if (roll < 85) return isq_pkg::POS_W'(planned_depth + $urandom_range(0, 2));
      if (roll < 95) return isq_pkg::POS_W'($urandom_range(0, 16'hFFFF));
      return '1;
   endfunction

   function automatic isq_pkg::value_type pick_value();
      case ($urandom_range(0, 9))
         0:       return {1'b1, {(isq_pkg::VALUE_W - 1){1'b0}}};
         1:       return {1'b0, {(isq_pkg::VALUE_W - 1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [isq_pkg::COUNT_W-1:0] pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return isq_pkg::COUNT_W'($urandom_range(0, 3));
      if (roll < 80) return isq_pkg::COUNT_W'($urandom_range(0, 24));
      if (roll < 92) return isq_pkg::COUNT_W'($urandom_range(0, STORE_DEPTH + 20));
      return isq_pkg::COUNT_W'($urandom_range(0, 16'hFFFF));
   endfunction

   // One random request word, weighted by the current mix
   function automatic isq_pkg::req_word_type random_word(mix_mode_type mode);
      isq_pkg::req_word_type w;
      int                    roll;
      w.position     = pick_position();
      w.item_value   = pick_value();
      w.erase_count  = pick_count();
      w.run_continue = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_GROW: begin
            w.req_type = (roll < 65) ? isq_pkg::REQ_INSERT : (roll < 75) ? isq_pkg::REQ_GET :
                         (roll < 85) ? isq_pkg::REQ_SET : (roll < 95) ? isq_pkg::REQ_ERASE :
                         isq_pkg::REQ_SIZE;
         end
         MODE_FILL: begin
            // insert until full, then keep knocking on the full store
            if (planned_depth < STORE_DEPTH || roll < 50) w.req_type = isq_pkg::REQ_INSERT;
            else if (roll < 75) w.req_type = isq_pkg::REQ_GET;
            else w.req_type = isq_pkg::REQ_SET;
         end
         MODE_SHRINK: begin
            w.req_type = (roll < 45) ? isq_pkg::REQ_ERASE : (roll < 65) ? isq_pkg::REQ_GET :
                         (roll < 75) ? isq_pkg::REQ_SET : (roll < 90) ? isq_pkg::REQ_INSERT :
                         isq_pkg::REQ_SIZE;
         end
         default: begin
            w.req_type = isq_pkg::CODE_W'($urandom_range(isq_pkg::REQ_INSERT, REQ_SPARE_HI));
         end
      endcase
      return w;
   endfunction

   // Hold a word on the port until the block takes it
   task automatic send_word(input isq_pkg::req_word_type w);
      req_word <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic issue(input isq_pkg::req_word_type w, input bit may_idle);
      send_word(w);
      track_depth(w);
      if (may_idle && $urandom_range(0, 99) < 25) hold_off($urandom_range(1, 9));
   endtask

   initial begin
      int                    counted;
      int                    batch;
      int                    roll;
      bit                    eager;
      mix_mode_type          mode;
      isq_pkg::req_word_type w;

      sb            = new();
      planned_depth = 0;
      counted       = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_word <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty store, appends past the end, runs, erase edge cases, spare codes
      issue(make_word(isq_pkg::REQ_SIZE,   0, '0, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_GET,    0, '0, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_ERASE,  0, '0, 1, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_SET,    0, '1, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_INSERT, 0, 32'h8000_0000, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_INSERT, 16'hFFFF, '1, 16'hFFFF, 1'b1), 1'b1);
      issue(make_word(isq_pkg::REQ_INSERT, 0, '0, 0, 1'b1), 1'b1);
      for (int i = 0; i < 4; i++) issue(make_word(isq_pkg::REQ_GET, i, '0, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_SET,    3, 32'h5A5A_A5A5, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_ERASE,  1, '0, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_ERASE,  2, '0, 16'hFFFF, 1'b0), 1'b1);
      // cursor now lies beyond the fill level: clamped, so this appends
      issue(make_word(isq_pkg::REQ_INSERT, 0, 32'd123, 0, 1'b1), 1'b1);
      issue(make_word(isq_pkg::REQ_GET,    2, '0, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_GET,    16'hFFFF, '0, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_SET,    16'hFFFF, 32'd7, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_ERASE,  3, '0, 1, 1'b0), 1'b1);
      for (int c = REQ_SPARE_LO; c <= REQ_SPARE_HI; c++)
         issue(make_word(isq_pkg::CODE_W'(c), c, pick_value(), c, 1'b1), 1'b1);
      issue(make_word(isq_pkg::REQ_SIZE,   0, '0, 0, 1'b0), 1'b1);
      issue(make_word(isq_pkg::REQ_ERASE,  0, '0, 3, 1'b0), 1'b1);

      // Random: batches of one mix each, some of them without idling
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         mode = (roll < 12) ? MODE_FILL : (roll < 40) ? MODE_GROW :
                (roll < 65) ? MODE_SHRINK : MODE_MIX;
         if (mode == MODE_FILL) batch = STORE_DEPTH - planned_depth + $urandom_range(4, 10);
         else batch = $urandom_range(20, 60);
         if (batch > RANDOM_ITEMS - counted) batch = RANDOM_ITEMS - counted;
         eager = ($urandom_range(0, 3) == 0);
         repeat (batch) begin
            w = random_word(mode);
            issue(w, !eager && counted < RANDOM_ITEMS - QUIET_TAIL);
            counted++;
         end
      end

      // Drain: every predicted word must arrive, then nothing more
      start <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d inserts, %0d erases, %0d gets, %0d sets, %0d size or spare codes",
               sb.op_seen[isq_pkg::REQ_INSERT], sb.op_seen[isq_pkg::REQ_ERASE],
               sb.op_seen[isq_pkg::REQ_GET], sb.op_seen[isq_pkg::REQ_SET],
               sb.op_seen[isq_pkg::REQ_SIZE]);
      $display("%0d responses checked, %0d full, %0d out of range, peak fill %0d, %0d mismatches",
               sb.checked, sb.full_rejects, sb.range_rejects, sb.peak_depth, sb.mismatches);
      if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
